@@ sv/letter_order_topological_sort_macros.svh @@
// Assertion macros used by the checker file.
`ifndef LETTER_ORDER_TOPOLOGICAL_SORT_MACROS_SVH
`define LETTER_ORDER_TOPOLOGICAL_SORT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LOTS_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LOTS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ sv/lots_pkg.sv @@
package lots_pkg;

	// Result status codes.
	localparam logic [2:0] ST_LETTER  = 3'd0;
	localparam logic [2:0] ST_PREFIX  = 3'd1;
	localparam logic [2:0] ST_CYCLE   = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_TOOLONG = 3'd4;

	// Sequencer states, one-hot.
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_COMP  = 9'b000000010,
		S_FIN   = 9'b000000100,
		S_DEG   = 9'b000001000,
		S_SCAN  = 9'b000010000,
		S_POP   = 9'b000100000,
		S_RELAX = 9'b001000000,
		S_EMIT  = 9'b010000000,
		S_STAT  = 9'b100000000
	} state_t;

endpackage

@@ sv/letter_order_topological_sort.sv @@
// Each letter is accepted, then compared against the stored word.
// At list end the sort checks for errors, adds the matrix rows into the in-degree counters,
// scans the letters, then pops and relaxes each placed letter; an error yields one status result.
// Results then leave at one per cycle through an output register unless out_stall holds them.
// Reset (arst_n low, asynchronous) clears all control state; after each list the
// block clears itself when its final result is registered.
module letter_order_topological_sort #(
	parameter int ALPHABET_SIZE = 26,
	parameter int MAX_WORD_LEN  = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [4:0] letter,
	input  logic       word_end,
	input  logic       list_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] order_letter,
	output logic [2:0] status,
	output logic       last
);
	import lots_pkg::*;

	localparam int LW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int CW = $clog2(ALPHABET_SIZE + 1);
	localparam int AW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int PW = $clog2(MAX_WORD_LEN + 1);
	localparam logic [CW-1:0] LAST_IDX = CW'(ALPHABET_SIZE - 1);

	state_t state_q;

	logic [4:0]    let_q;
	logic          we_q, le_q;
	logic [4:0]    rd_q;
	logic [4:0]    word_mem [MAX_WORD_LEN];
	logic [PW-1:0] pos_q, prev_len_q;
	logic          diff_q, prefix_q, len_err_q;
	logic [ALPHABET_SIZE-1:0] edge_q [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] present_q;
	logic [CW-1:0] indeg_q [ALPHABET_SIZE];
	logic [LW-1:0] queue_q [ALPHABET_SIZE];
	logic [CW-1:0] head_q, tail_q, idx_q, total_q;
	logic [LW-1:0] u_q;
	logic [2:0]    st_q;
	logic          ov_q;
	logic [4:0]    ol_q;
	logic [2:0]    os_q;
	logic          olast_q;

	logic          in_acc, slot_free, emit_go;
	logic          let_ok, pos_ok, differ_now, edge_ok, word_done;
	logic [PW-1:0] new_pos;
	logic [LW-1:0] idx_l;
	logic [LW-1:0] q_rd;
	logic [ALPHABET_SIZE-1:0] row;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !ov_q || !out_stall;
	assign emit_go   = ((state_q == S_EMIT) || (state_q == S_STAT)) && slot_free;
	assign out_valid    = ov_q;
	assign order_letter = ol_q;
	assign status       = os_q;
	assign last         = olast_q;

	// Comparison of the current letter with the stored previous word.
	always_comb begin
		let_ok     = (let_q < 5'(ALPHABET_SIZE));
		pos_ok     = (pos_q < PW'(MAX_WORD_LEN));
		new_pos    = pos_ok ? pos_q + PW'(1) : pos_q;
		differ_now = pos_ok && !diff_q && (pos_q < prev_len_q) && (rd_q != let_q);
		edge_ok    = differ_now && let_ok && (rd_q < 5'(ALPHABET_SIZE));
		word_done  = we_q || le_q;
		idx_l      = idx_q[LW-1:0];
		row        = (state_q == S_RELAX) ? edge_q[u_q] : edge_q[idx_l];
		q_rd       = (state_q == S_EMIT) ? queue_q[idx_l] : queue_q[head_q[LW-1:0]];
	end

	// Previous word store: read on transfer, written in the compare cycle.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_q <= word_mem[pos_q[AW-1:0]];
		end
		if (state_q == S_COMP && pos_ok) begin
			word_mem[pos_q[AW-1:0]] <= let_q;
		end
	end

	// Input letter holding register.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			let_q <= letter;
			we_q  <= word_end;
			le_q  <= list_end;
		end
	end

	// Sequencer with the shared degree and relax step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pos_q      <= '0;
			prev_len_q <= '0;
			diff_q     <= 1'b0;
			prefix_q   <= 1'b0;
			len_err_q  <= 1'b0;
			present_q  <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			idx_q      <= '0;
			total_q    <= '0;
			u_q        <= '0;
			st_q       <= ST_LETTER;
			ov_q       <= 1'b0;
			ol_q       <= '0;
			os_q       <= ST_LETTER;
			olast_q    <= 1'b0;
			for (int i = 0; i < ALPHABET_SIZE; i++) begin
				edge_q[i]  <= '0;
				indeg_q[i] <= '0;
				queue_q[i] <= '0;
			end
		end else begin
			if (ov_q && !out_stall && !emit_go) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_COMP;
					end
				end
				S_COMP: begin
					if (let_ok) begin
						present_q[let_q[LW-1:0]] <= 1'b1;
					end
					if (edge_ok) begin
						edge_q[rd_q[LW-1:0]][let_q[LW-1:0]] <= 1'b1;
					end
					if (!pos_ok) begin
						len_err_q <= 1'b1;
					end
					if (word_done) begin
						if (!(diff_q || differ_now) && (prev_len_q > new_pos)) begin
							prefix_q <= 1'b1;
						end
						prev_len_q <= new_pos;
						pos_q      <= '0;
						diff_q     <= 1'b0;
					end else begin
						pos_q  <= new_pos;
						diff_q <= diff_q || differ_now;
					end
					state_q <= le_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					idx_q   <= '0;
					total_q <= '0;
					if (len_err_q) begin
						st_q    <= ST_TOOLONG;
						state_q <= S_STAT;
					end else if (prefix_q) begin
						st_q    <= ST_PREFIX;
						state_q <= S_STAT;
					end else if (present_q == '0) begin
						st_q    <= ST_EMPTY;
						state_q <= S_STAT;
					end else begin
						state_q <= S_DEG;
					end
				end
				S_DEG: begin
					// Add one matrix row into every in-degree counter.
					for (int v = 0; v < ALPHABET_SIZE; v++) begin
						indeg_q[v] <= indeg_q[v] + CW'(row[v]);
					end
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= S_SCAN;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_SCAN: begin
					if (present_q[idx_l]) begin
						total_q <= total_q + CW'(1);
						if (indeg_q[idx_l] == '0) begin
							queue_q[tail_q[LW-1:0]] <= idx_l;
							tail_q <= tail_q + CW'(1);
						end
					end
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= S_POP;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_POP: begin
					idx_q <= '0;
					if (head_q < tail_q) begin
						u_q     <= q_rd;
						head_q  <= head_q + CW'(1);
						state_q <= S_RELAX;
					end else if (tail_q == total_q) begin
						state_q <= S_EMIT;
					end else begin
						st_q    <= ST_CYCLE;
						state_q <= S_STAT;
					end
				end
				S_RELAX: begin
					// Visit one target of the popped letter.
					if (row[idx_l] && indeg_q[idx_l] != '0) begin
						indeg_q[idx_l] <= indeg_q[idx_l] - CW'(1);
						if (indeg_q[idx_l] == CW'(1)) begin
							queue_q[tail_q[LW-1:0]] <= idx_l;
							tail_q <= tail_q + CW'(1);
						end
					end
					if (idx_q == LAST_IDX) begin
						state_q <= S_POP;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_EMIT, S_STAT: begin
					if (slot_free) begin
						ov_q <= 1'b1;
						if (state_q == S_EMIT) begin
							ol_q    <= 5'(q_rd);
							os_q    <= ST_LETTER;
							olast_q <= (idx_q + CW'(1) == tail_q);
						end else begin
							ol_q    <= '0;
							os_q    <= st_q;
							olast_q <= 1'b1;
						end
						idx_q <= idx_q + CW'(1);
						if (state_q == S_STAT || idx_q + CW'(1) == tail_q) begin
							// Final transfer of the list: clear the word, matrix, degree and queue state.
							state_q    <= S_IDLE;
							prev_len_q <= '0;
							prefix_q   <= 1'b0;
							len_err_q  <= 1'b0;
							present_q  <= '0;
							head_q     <= '0;
							tail_q     <= '0;
							for (int i = 0; i < ALPHABET_SIZE; i++) begin
								edge_q[i]  <= '0;
								indeg_q[i] <= '0;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/lots_checker.sv @@
`include "letter_order_topological_sort_macros.svh"

module lots_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [4:0] order_letter,
	input logic [2:0] status,
	input logic       last
);
	import lots_pkg::*;

	// A stalled result stays offered unchanged.
	`LOTS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(order_letter) && $stable(status) && $stable(last), "stalled result changed")

	// A status result is always the only and final result of its list.
	`LOTS_ASSERT_NOW(a_stat_last, out_valid && status != ST_LETTER, last, "status result not last")

	// A status result carries no letter.
	`LOTS_ASSERT_NOW(a_stat_zero, out_valid && status != ST_LETTER, order_letter == 5'd0, "status result with letter")

	// Only defined status codes appear.
	`LOTS_ASSERT_NOW(a_stat_code, out_valid, status <= ST_TOOLONG, "undefined status code")

endmodule

bind letter_order_topological_sort lots_checker u_lots_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.order_letter (order_letter),
	.status       (status),
	.last         (last)
);
